FILE: rtl/dfr_pkg.sv
// Package for the DES Feistel round: E, P and S-box tables and the round helpers.
// No dependencies; used by des_feistel_round_top.
`timescale 1ns / 1ps

package dfr_pkg;

  localparam int unsigned BlockW = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned KeyW   = 48;

  typedef logic [5:0] des_pos_t;

  // Expansion table: DES bit positions of the right half, bit 1 is the MSB.
  localparam des_pos_t EXP_TAB [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
    6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
    6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
    6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
    6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  // Permutation applied to the S-box output.
  localparam des_pos_t PERM_TAB [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  // The eight standard S-boxes, indexed by box, row and column.
  localparam logic [3:0] SBOX_TAB [8][4][16] = '{
    '{'{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7},
      '{4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8},
      '{4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0},
      '{4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13}},
    '{'{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10},
      '{4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5},
      '{4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15},
      '{4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9}},
    '{'{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8},
      '{4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1},
      '{4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7},
      '{4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12}},
    '{'{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15},
      '{4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9},
      '{4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4},
      '{4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14}},
    '{'{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9},
      '{4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6},
      '{4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14},
      '{4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3}},
    '{'{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11},
      '{4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8},
      '{4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6},
      '{4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13}},
    '{'{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1},
      '{4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6},
      '{4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2},
      '{4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12}},
    '{'{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7},
      '{4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2},
      '{4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8},
      '{4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}}
  };

  // Bit n of a 32-bit half in DES numbering, where bit 1 is the MSB.
  function automatic logic half_bit(input logic [HalfW-1:0] v, input des_pos_t n);
    logic [4:0] idx;
    idx = 5'(6'd32 - n);
    return v[idx];
  endfunction

  // Expand the right half to 48 bits.
  function automatic logic [KeyW-1:0] expand_half(input logic [HalfW-1:0] r);
    logic [KeyW-1:0] e;
    e = '0;
    for (int i = 0; i < KeyW; i++) begin
      e[KeyW-1-i] = half_bit(r, EXP_TAB[i]);
    end
    return e;
  endfunction

  // Eight parallel S-box lookups; outer bits pick the row, middle bits the column.
  function automatic logic [HalfW-1:0] substitute(input logic [KeyW-1:0] x);
    logic [HalfW-1:0] s;
    logic [5:0]       six;
    logic [1:0]       row;
    logic [3:0]       col;
    s = '0;
    for (int g = 0; g < 8; g++) begin
      six = x[KeyW-1-6*g -: 6];
      row = {six[5], six[0]};
      col = six[4:1];
      s[HalfW-1-4*g -: 4] = SBOX_TAB[g][row][col];
    end
    return s;
  endfunction

  // P permutation of the substituted half.
  function automatic logic [HalfW-1:0] permute_half(input logic [HalfW-1:0] v);
    logic [HalfW-1:0] p;
    p = '0;
    for (int i = 0; i < HalfW; i++) begin
      p[HalfW-1-i] = half_bit(v, PERM_TAB[i]);
    end
    return p;
  endfunction

endpackage

FILE: rtl/des_feistel_round_top.sv
// An accepted input beat goes into the input register, then into the result register when
// that register is free, and is offered on the output from there.
// Throughput: one block per cycle when not stalled; the round is wiring, XORs and table
// lookups between the two registers, and the result register frees as its beat is taken.
// Reset clears both valid flags; the data registers are not reset.
// Depends on dfr_pkg for the round tables and helper functions.
`timescale 1ns / 1ps

module des_feistel_round_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dfr_pkg::BlockW-1:0]  block_in_i,
  input  logic [dfr_pkg::KeyW-1:0]    round_key_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [dfr_pkg::BlockW-1:0]  block_out_o
);

  logic                       in_vld_q;
  logic [dfr_pkg::BlockW-1:0] blk_q;
  logic [dfr_pkg::KeyW-1:0]   key_q;
  logic                       res_vld_q;
  logic [dfr_pkg::BlockW-1:0] res_q;
  logic [dfr_pkg::BlockW-1:0] res_d;
  logic [dfr_pkg::HalfW-1:0]  left;
  logic [dfr_pkg::HalfW-1:0]  right;
  logic [dfr_pkg::HalfW-1:0]  f_out;
  logic                       res_free;
  logic                       advance;

  // Handshake: the input stage moves on when the result register is free.
  assign res_free   = !res_vld_q || out_ready_i;
  assign advance    = in_vld_q && res_free;
  assign in_ready_o = !in_vld_q || res_free;

  // Round function on the registered beat.
  assign left  = blk_q[dfr_pkg::BlockW-1:dfr_pkg::HalfW];
  assign right = blk_q[dfr_pkg::HalfW-1:0];
  assign f_out = dfr_pkg::permute_half(
                   dfr_pkg::substitute(dfr_pkg::expand_half(right) ^ key_q));
  assign res_d = {right, f_out ^ left};

  // Valid flags of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (res_free) begin
        res_vld_q <= in_vld_q;
      end
    end
  end

  // Data registers, loaded on an accepted beat.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      blk_q <= block_in_i;
      key_q <= round_key_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_vld_q;
  assign block_out_o = res_q;

endmodule
